/* rtl/lcs_pkg.sv */
// shared types and constants for the longest common substring block
`timescale 1ns / 1ps

package lcs_pkg;

  localparam int MAX_LEN_DEF = 32;
  localparam int SYM_W       = 8;

  // input function codes
  localparam logic [1:0] FUNC_APPEND_A = 2'd0;
  localparam logic [1:0] FUNC_APPEND_B = 2'd1;
  localparam logic [1:0] FUNC_RUN      = 2'd2;

  typedef enum logic [1:0] {
    KIND_APPEND_A,
    KIND_APPEND_B,
    KIND_RUN
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [SYM_W-1:0] symbol;
  } queue_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMPTY
  } state_t;

endpackage

/* rtl/lcs_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lcs_front.sv */
// front end: accepts transactions, classifies them and queues them for the back end
`timescale 1ns / 1ps

module lcs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic [7:0]          symbol,
  output logic                q_valid,
  output lcs_pkg::queue_item_t q_item,
  input  logic                q_pop
);

  import lcs_pkg::*;

  queue_item_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  queue_item_t item_in;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];
  assign pop      = q_pop && q_valid;
  // the unused function code is taken and dropped here
  assign push     = in_valid && in_ready &&
                    (func == FUNC_APPEND_A || func == FUNC_APPEND_B || func == FUNC_RUN);

  always_comb begin
    item_in.symbol = symbol;
    unique case (func)
      FUNC_APPEND_A: item_in.kind = KIND_APPEND_A;
      FUNC_APPEND_B: item_in.kind = KIND_APPEND_B;
      default:       item_in.kind = KIND_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/lcs_back.sv */
// back end: string stores, diagonal match scan and result emission
`timescale 1ns / 1ps

module lcs_back #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  lcs_pkg::queue_item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [5:0]           match_length,
  output logic [4:0]           start_in_a,
  output logic [4:0]           start_in_b,
  output logic [7:0]           out_symbol,
  output logic                 symbol_valid,
  output logic                 truncated,
  output logic                 last
);

  import lcs_pkg::*;

  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);
  localparam logic [LW-1:0] ONE     = LW'(1);

  state_t state, state_next;

  logic [LW-1:0] len_a, len_a_next, len_b, len_b_next;
  logic          ovf, ovf_next;
  logic [IW-1:0] ia, ia_next, ib, ib_next;
  logic [LW-1:0] sr, sr_next;
  logic          phase_b, phase_b_next;
  logic [LW-1:0] k, k_next;
  logic [LW-1:0] best_len, best_len_next;
  logic [IW-1:0] best_ia, best_ia_next, best_ib, best_ib_next;

  // scan pipeline: stage 1 waits on ram data, stage 2 holds the run length
  logic          v1, v1_next, first1;
  logic [IW-1:0] ia1, ib1;
  logic          v2;
  logic [LW-1:0] run2;
  logic [IW-1:0] ia2, ib2;

  logic            we_a, we_b;
  logic [IW-1:0]   raddr_a;
  logic [SYM_W-1:0] rdata_a, rdata_b;
  logic            out_free, load_out, load_last, load_empty;

  logic [LW-1:0] start_a, start_b;
  logic          end_diag, better;

  assign start_a  = LW'(best_ia) + ONE - best_len;
  assign start_b  = LW'(best_ib) + ONE - best_len;
  assign out_free = !out_valid || out_ready;
  assign raddr_a  = (state == ST_SCAN) ? ia : IW'(start_a + k);
  assign end_diag = (LW'(ia) == len_a - ONE) || (LW'(ib) == len_b - ONE);
  assign better   = v2 && (run2 != '0) &&
                    ((run2 > best_len) ||
                     ((run2 == best_len) &&
                      ((ia2 < best_ia) || ((ia2 == best_ia) && (ib2 < best_ib)))));

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (IW'(len_a)),
    .wdata (q_item.symbol),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (IW'(len_b)),
    .wdata (q_item.symbol),
    .raddr (ib),
    .rdata (rdata_b)
  );

  always_comb begin
    state_next    = state;
    len_a_next    = len_a;
    len_b_next    = len_b;
    ovf_next      = ovf;
    ia_next       = ia;
    ib_next       = ib;
    sr_next       = sr;
    phase_b_next  = phase_b;
    k_next        = k;
    best_len_next = best_len;
    best_ia_next  = best_ia;
    best_ib_next  = best_ib;
    v1_next       = 1'b0;
    q_pop         = 1'b0;
    we_a          = 1'b0;
    we_b          = 1'b0;
    load_out      = 1'b0;
    load_last     = 1'b0;
    load_empty    = 1'b0;

    if (better) begin
      best_len_next = run2;
      best_ia_next  = ia2;
      best_ib_next  = ib2;
    end

    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.kind)
            KIND_APPEND_A: begin
              if (len_a < LEN_MAX) begin
                we_a       = 1'b1;
                len_a_next = len_a + ONE;
              end else begin
                ovf_next = 1'b1;
              end
            end
            KIND_APPEND_B: begin
              if (len_b < LEN_MAX) begin
                we_b       = 1'b1;
                len_b_next = len_b + ONE;
              end else begin
                ovf_next = 1'b1;
              end
            end
            default: begin
              best_len_next = '0;
              best_ia_next  = '0;
              best_ib_next  = '0;
              ia_next       = '0;
              ib_next       = '0;
              sr_next       = '0;
              phase_b_next  = 1'b0;
              if (len_a == '0 || len_b == '0) begin
                state_next = ST_EMPTY;
              end else begin
                state_next = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        v1_next = 1'b1;
        if (!end_diag) begin
          ia_next = ia + IW'(1);
          ib_next = ib + IW'(1);
        end else if (!phase_b) begin
          if (sr + ONE < len_a) begin
            sr_next = sr + ONE;
            ia_next = IW'(sr + ONE);
            ib_next = '0;
          end else if (ONE < len_b) begin
            phase_b_next = 1'b1;
            sr_next      = ONE;
            ia_next      = '0;
            ib_next      = IW'(ONE);
          end else begin
            state_next = ST_DRAIN;
          end
        end else begin
          if (sr + ONE < len_b) begin
            sr_next = sr + ONE;
            ia_next = '0;
            ib_next = IW'(sr + ONE);
          end else begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          k_next = '0;
          if (best_len == '0) begin
            state_next = ST_EMPTY;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_last = (k + ONE == best_len);
          k_next    = k + ONE;
          if (load_last) begin
            len_a_next = '0;
            len_b_next = '0;
            ovf_next   = 1'b0;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_last  = 1'b1;
          load_empty = 1'b1;
          len_a_next = '0;
          len_b_next = '0;
          ovf_next   = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len_a     <= '0;
      len_b     <= '0;
      ovf       <= 1'b0;
      best_len  <= '0;
      best_ia   <= '0;
      best_ib   <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      len_a    <= len_a_next;
      len_b    <= len_b_next;
      ovf      <= ovf_next;
      best_len <= best_len_next;
      best_ia  <= best_ia_next;
      best_ib  <= best_ib_next;
      v1       <= v1_next;
      v2       <= v1;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ia      <= ia_next;
    ib      <= ib_next;
    sr      <= sr_next;
    phase_b <= phase_b_next;
    k       <= k_next;
    first1  <= (ia == '0) || (ib == '0);
    ia1     <= ia;
    ib1     <= ib;
    ia2     <= ia1;
    ib2     <= ib1;
    if (rdata_a == rdata_b) begin
      run2 <= first1 ? ONE : run2 + ONE;
    end else begin
      run2 <= '0;
    end
    if (load_out) begin
      truncated <= ovf;
      last      <= load_last;
      if (load_empty) begin
        match_length <= '0;
        start_in_a   <= '0;
        start_in_b   <= '0;
        out_symbol   <= '0;
        symbol_valid <= 1'b0;
      end else begin
        match_length <= 6'(best_len);
        start_in_a   <= 5'(start_a);
        start_in_b   <= 5'(start_b);
        out_symbol   <= rdata_a;
        symbol_valid <= 1'b1;
      end
    end
  end

endmodule

/* rtl/longest_common_substring.sv */
// top level of the longest common substring block
`timescale 1ns / 1ps

// Longest common substring of two byte strings. Each input transaction appends
// one symbol to string A (func 0) or string B (func 1), up to MAX_LEN each;
// symbols past that are dropped and the truncated flag is raised. A run
// transaction (func 2) searches all match lengths and emits the first longest
// common run in row-major order, one symbol per output transaction, each
// carrying the length and both start positions, with last on the final one.
// An empty string or no common symbol gives one output with length 0 and
// symbol_valid low. After a run both strings are empty and truncated clears.
// Timing: the front end queues two transactions, so appends sustain one per
// cycle while no run is in progress. A run walks every cell of the len_a x
// len_b table once along its diagonals through the string rams, one cell per
// cycle, holding the queue meanwhile, then emits each symbol via a ram read
// state and then an output register load state. Func 3 is taken and dropped.

module longest_common_substring #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] symbol,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] match_length,
  output logic [4:0] start_in_a,
  output logic [4:0] start_in_b,
  output logic [7:0] out_symbol,
  output logic       symbol_valid,
  output logic       truncated,
  output logic       last
);

  import lcs_pkg::*;

  // queue between front and back ends
  logic        q_valid;
  logic        q_pop;
  queue_item_t q_item;

  lcs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .symbol   (symbol),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lcs_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .match_length (match_length),
    .start_in_a   (start_in_a),
    .start_in_b   (start_in_b),
    .out_symbol   (out_symbol),
    .symbol_valid (symbol_valid),
    .truncated    (truncated),
    .last         (last)
  );

endmodule
